### rtl/gld_pkg.sv
// Shared types, constants and helpers for the GIF LZW decoder.
`default_nettype none
package gld_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;
    localparam int unsigned CODE_W = 12;
    localparam int unsigned CNT_W = 13;
    localparam logic [3:0] MAX_WIDTH = 4'd12;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STARVED  = 3'd1,
        ST_PADDED   = 3'd2,
        ST_COMPLETE = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_MIN_CODE_SIZE = 1'b0,
        REG_PIXEL_COUNT   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_CHAIN,
        S_FIN,
        S_POP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_CODE    = 2'd1,
        END_INVALID = 2'd2
    } end_t;

    // Saturate the minimum code size into 1..8.
    function automatic logic [3:0] root_bits(input logic [3:0] mcs);
        logic [3:0] r;
        if (mcs == 4'd0) r = 4'd1;
        else if (mcs > 4'd8) r = 4'd8;
        else r = mcs;
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/gld_if.sv
// Valid/ready channel interfaces for input items and result words.
`default_nettype none
interface gld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface gld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic [2:0] status;
    logic       stream_error;
    modport source (output valid, output pixel, output status, output stream_error,
                    input ready);
    modport sink (input valid, input pixel, input status, input stream_error,
                  output ready);
endinterface
`default_nettype wire

### rtl/gld_code_reader.sv
// LSB-first bit buffer that packs bytes in and takes codes out.
`default_nettype none
module gld_code_reader
    import gld_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              push,
    input  wire logic [7:0]        data_byte,
    input  wire logic              take,
    input  wire logic [3:0]        width,
    output logic [CODE_W-1:0]      code,
    output logic [5:0]             count
);
    logic [31:0] buf_reg, buf_next;
    logic [5:0]  cnt_reg, cnt_next;

    // Mask the low bits of the buffer to the current width
    assign code  = buf_reg[CODE_W-1:0] & ((CODE_W'(1) << width) - CODE_W'(1));
    assign count = cnt_reg;

    // Append bytes above the held bits, drop consumed codes
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (clear)
        begin
            buf_next = '0;
            cnt_next = '0;
        end
        else if (push)
        begin
            buf_next = buf_reg | ({24'd0, data_byte} << cnt_reg);
            cnt_next = cnt_reg + 6'd8;
        end
        else if (take)
        begin
            buf_next = buf_reg >> width;
            cnt_next = cnt_reg - {2'b00, width};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

### rtl/gif_lzw_decoder_core.sv
// GIF LZW decoder top level: control, string table and pixel stack.
// Each input word is one operation: push a compressed byte, pull one pixel,
// or restart the stream. Every word yields exactly one result word. Push,
// restart and idle words are accepted and then return their result. A pull
// that finds pixels on the stack is accepted, checked, reads the stack and
// returns the pixel. A pull that must decode is accepted, consumes codes,
// walks the prefix chain through the string table at one entry a cycle,
// adds the table entry, then checks, reads the stack and returns the pixel.
// The remaining pixels of a string are then served from the stack, one per
// pull. A result word that waits on the output holds the block until it is
// taken. Tables are not cleared after reset; only entries written by the
// current stream are ever read.
`default_nettype none
module gif_lzw_decoder_core
    import gld_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    gld_in_if.sink           in_ch,
    gld_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // Memories
    logic [CODE_W-1:0] prefix_mem [TABLE_DEPTH];
    logic [7:0]        suffix_mem [TABLE_DEPTH];
    logic [7:0]        stack_mem  [TABLE_DEPTH];
    logic [CODE_W-1:0] prefix_q;
    logic [7:0]        suffix_q, stack_q;

    state_t            state_reg, state_next;
    logic [3:0]        mcs_reg;
    logic [23:0]       pcount_reg;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [3:0]        cw_reg, cw_next;
    logic [CNT_W-1:0]  nfe_reg, nfe_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic              pv_reg, pv_next;
    logic [7:0]        first_reg, first_next;
    logic [23:0]       deliv_reg, deliv_next;
    end_t              ended_reg, ended_next;
    logic [CODE_W-1:0] c_reg, c_next;
    logic [CODE_W-1:0] in_code_reg, in_code_next;
    logic [7:0]        res_pixel_reg, res_pixel_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg;
    logic [7:0]        out_pixel_reg;
    logic [2:0]        out_status_reg;
    logic              out_err_reg;

    logic              stk_we, tbl_we, rd_clear, rd_push, rd_take, in_fire, out_load;
    logic [7:0]        stk_wdata;
    logic [ADDR_W-1:0] stk_raddr, tbl_raddr;
    logic [CODE_W-1:0] code;
    logic [5:0]        bit_cnt;
    logic [3:0]        root;
    logic [CNT_W-1:0]  clr, code_w, c_w, pq_w, nfe_inc;
    logic [CODE_W-1:0] c_sel;

    assign root    = root_bits(mcs_reg);
    assign clr     = CNT_W'(1) << root;
    assign code_w  = {1'b0, code};
    assign pq_w    = {1'b0, prefix_q};
    assign nfe_inc = nfe_reg + CNT_W'(1);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    gld_code_reader u_reader (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (rd_clear),
        .push      (rd_push),
        .data_byte (in_ch.data_byte),
        .take      (rd_take),
        .width     (cw_reg),
        .code      (code),
        .count     (bit_cnt)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg    <= 4'd8;
            pcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MIN_CODE_SIZE: mcs_reg <= cfg_data[3:0];
                REG_PIXEL_COUNT:   pcount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        c_w        = code_w;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (op_t'(in_ch.op) == OP_PULL && deliv_reg < pcount_reg)
                        state_next = S_LOOP;
                    else
                        state_next = S_DONE;
                end
            end
            S_LOOP:
            begin
                if (depth_reg == '0 && ended_reg == END_NONE && bit_cnt >= {2'b00, cw_reg})
                begin
                    if (code_w != clr && code_w != clr + CNT_W'(1) && code_w <= nfe_reg
                        && code_w < DEPTH_C && pv_reg)
                    begin
                        c_w = (code_w == nfe_reg) ? {1'b0, prev_reg} : code_w;
                        state_next = (c_w > clr && c_w < DEPTH_C) ? S_CHAIN : S_FIN;
                    end
                end
                else if (depth_reg != '0)
                    state_next = S_POP;
                else
                    state_next = S_DONE;
            end
            S_CHAIN:
            begin
                if (!(pq_w > clr && pq_w < DEPTH_C))
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_LOOP;
            S_POP:   state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        depth_next      = depth_reg;
        cw_next         = cw_reg;
        nfe_next        = nfe_reg;
        prev_next       = prev_reg;
        pv_next         = pv_reg;
        first_next      = first_reg;
        deliv_next      = deliv_reg;
        ended_next      = ended_reg;
        c_next          = c_reg;
        in_code_next    = in_code_reg;
        res_pixel_next  = res_pixel_reg;
        res_status_next = res_status_reg;
        stk_we          = 1'b0;
        stk_wdata       = '0;
        tbl_we          = 1'b0;
        rd_clear        = 1'b0;
        rd_push         = 1'b0;
        rd_take         = 1'b0;
        stk_raddr       = ADDR_W'(depth_reg - CNT_W'(1));
        c_sel           = c_reg;
        tbl_raddr       = c_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_pixel_next  = '0;
                    res_status_next = ST_OK;
                    unique case (op_t'(in_ch.op))
                        OP_PUSH:
                        begin
                            if (bit_cnt <= 6'd24) rd_push = 1'b1;
                            else res_status_next = ST_FULL;
                        end
                        OP_PULL:
                        begin
                            if (deliv_reg >= pcount_reg) res_status_next = ST_COMPLETE;
                        end
                        OP_START:
                        begin
                            rd_clear   = 1'b1;
                            depth_next = '0;
                            cw_next    = root + 4'd1;
                            nfe_next   = clr + CNT_W'(2);
                            prev_next  = '0;
                            pv_next    = 1'b0;
                            first_next = '0;
                            deliv_next = '0;
                            ended_next = END_NONE;
                        end
                        OP_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_LOOP:
            begin
                if (depth_reg == '0 && ended_reg == END_NONE && bit_cnt >= {2'b00, cw_reg})
                begin
                    rd_take = 1'b1;
                    priority if (code_w == clr)
                    begin
                        cw_next  = root + 4'd1;
                        nfe_next = clr + CNT_W'(2);
                        pv_next  = 1'b0;
                    end
                    else if (code_w == clr + CNT_W'(1))
                        ended_next = END_CODE;
                    else if (code_w > nfe_reg || code_w >= DEPTH_C)
                        ended_next = END_INVALID;
                    else if (!pv_reg)
                    begin
                        if (code_w > clr)
                            ended_next = END_INVALID;
                        else
                        begin
                            stk_we     = 1'b1;
                            stk_wdata  = code[7:0];
                            prev_next  = code;
                            first_next = code[7:0];
                            pv_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        in_code_next = code;
                        c_sel = code;
                        if (code_w == nfe_reg)
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = first_reg;
                            c_sel     = prev_reg;
                        end
                        c_next    = c_sel;
                        tbl_raddr = c_sel[ADDR_W-1:0];
                    end
                end
                else if (depth_reg != '0)
                    depth_next = depth_reg - CNT_W'(1);
                else if (ended_reg != END_NONE)
                begin
                    res_status_next = ST_PADDED;
                    deliv_next      = deliv_reg + 24'd1;
                end
                else
                    res_status_next = ST_STARVED;
            end
            S_CHAIN:
            begin
                stk_we    = 1'b1;
                stk_wdata = suffix_q;
                c_next    = prefix_q;
                tbl_raddr = prefix_q[ADDR_W-1:0];
            end
            S_FIN:
            begin
                first_next = c_reg[7:0];
                stk_we     = 1'b1;
                stk_wdata  = c_reg[7:0];
                prev_next  = in_code_reg;
                if (nfe_reg < DEPTH_C)
                begin
                    tbl_we   = 1'b1;
                    nfe_next = nfe_inc;
                    if ((nfe_inc & ((CNT_W'(1) << cw_reg) - CNT_W'(1))) == '0
                        && nfe_inc < DEPTH_C && cw_reg < MAX_WIDTH)
                        cw_next = cw_reg + 4'd1;
                end
            end
            S_POP:
            begin
                res_pixel_next  = stack_q;
                res_status_next = ST_OK;
                deliv_next      = deliv_reg + 24'd1;
            end
            S_DONE: ;
            default: ;
        endcase
        // Drop pushes beyond the stack's capacity
        if (stk_we)
        begin
            if (depth_reg < DEPTH_C) depth_next = depth_reg + CNT_W'(1);
            else stk_we = 1'b0;
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel      = out_pixel_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.stream_error = out_err_reg;

    // Memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            prefix_mem[nfe_reg[ADDR_W-1:0]] <= prev_reg;
            suffix_mem[nfe_reg[ADDR_W-1:0]] <= c_reg[7:0];
        end
        prefix_q <= prefix_mem[tbl_raddr];
        suffix_q <= suffix_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we) stack_mem[depth_reg[ADDR_W-1:0]] <= stk_wdata;
        stack_q <= stack_mem[stk_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            cw_reg        <= 4'd9;
            nfe_reg       <= CNT_W'(258);
            prev_reg      <= '0;
            pv_reg        <= 1'b0;
            first_reg     <= '0;
            deliv_reg     <= '0;
            ended_reg     <= END_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            cw_reg    <= cw_next;
            nfe_reg   <= nfe_next;
            prev_reg  <= prev_next;
            pv_reg    <= pv_next;
            first_reg <= first_next;
            deliv_reg <= deliv_next;
            ended_reg <= ended_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        in_code_reg    <= in_code_next;
        res_pixel_reg  <= res_pixel_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_pixel_reg  <= res_pixel_reg;
            out_status_reg <= res_status_reg;
            out_err_reg    <= (ended_reg == END_INVALID);
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_C) else $error("pixel stack overran");
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cw_reg <= MAX_WIDTH) else $error("code width beyond limit");
    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfe_reg <= DEPTH_C) else $error("table grew past its depth");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready) else $error("word accepted while busy");
    a_pad_only_ended: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_status_reg == ST_PADDED |-> ended_reg != END_NONE)
        else $error("padded pixel on a running stream");
`endif
endmodule
`default_nettype wire
